FILE: design/sob_pkg.sv
// Package for the Sobel edge magnitude block: shared types, constants and the
// kernel function. Used by sob_front, sob_queue and sob_back.
`timescale 1ns / 1ps

package sob_pkg;

    // BT.601 luma coefficients
    localparam logic [16:0] LUMA_R   = 17'd66;
    localparam logic [16:0] LUMA_G   = 17'd129;
    localparam logic [16:0] LUMA_B   = 17'd25;
    localparam logic [16:0] LUMA_RND = 17'd128;
    localparam logic [7:0]  LUMA_OFS = 8'd16;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // window index row*3+col; rows top, mid, bottom; cols left, mid, right
    typedef logic [8:0][7:0] t_win;

    typedef struct packed {
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic               row_end;
        logic               frame_end;
        logic               last;
    } t_job;

    function automatic t_job grad(input t_win w);
        int   gx;
        int   gy;
        t_job j;
        gx = (int'(w[2]) + 2 * int'(w[5]) + int'(w[8]))
           - (int'(w[0]) + 2 * int'(w[3]) + int'(w[6]));
        gy = (int'(w[6]) + 2 * int'(w[7]) + int'(w[8]))
           - (int'(w[0]) + 2 * int'(w[1]) + int'(w[2]));
        j.gx        = 11'(gx);
        j.gy        = 11'(gy);
        j.row_end   = 1'b0;
        j.frame_end = 1'b0;
        j.last      = 1'b0;
        return j;
    endfunction

endpackage

FILE: design/sob_queue.sv
// Short job queue between front and back of the Sobel block.
// Depends on sob_pkg for the job type and depth.
`timescale 1ns / 1ps

module sob_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sob_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sob_pkg::t_job o_data
);

    sob_pkg::t_job r_mem [sob_pkg::Q_DEPTH];
    logic [sob_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [sob_pkg::Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (sob_pkg::Q_AW+1)'(sob_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: design/sob_front.sv
// Front of the Sobel block: luma conversion, line stores, 3x3 window and
// frame counters; emits gradient jobs. Depends on sob_pkg.
`timescale 1ns / 1ps

module sob_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [12:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_opcode,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_red,
    output logic          o_push,
    output sob_pkg::t_job o_job,
    input  logic          i_full
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_PIX  = 6'b000010,
        F_EDGE = 6'b000100,
        F_DR1  = 6'b001000,
        F_DR2  = 6'b010000,
        F_DR3  = 6'b100000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [11:0]   r_cfg_w;
    logic [12:0]   r_cfg_h;
    logic [CW-1:0] r_col, n_col, r_drain, n_drain, r_c, n_c;
    logic [HW-1:0] r_row, n_row;
    logic [7:0]    r_y, n_y;
    sob_pkg::t_win r_win, n_win;
    logic [CW-1:0] r_rdaddr, n_rdaddr;
    logic [7:0]    r_rd_a, r_rd_b;
    logic [7:0]    mem_a [MAX_WIDTH];
    logic [7:0]    mem_b [MAX_WIDTH];
    logic          mem_we;

    logic [17:0]   w18, h18;
    logic [CW-1:0] w, c_now, d_now, col0_now, col2;
    logic [HW-1:0] h;
    logic [16:0]   lsum;
    logic [7:0]    luma, pt, pm;
    sob_pkg::t_win win_pix, win_edge, win_dr;
    logic          need_out;

    always_comb begin
        w18 = 18'(r_cfg_w);
        if (w18 < 18'd2) begin
            w18 = 18'd2;
        end else if (w18 > 18'(MAX_WIDTH)) begin
            w18 = 18'(MAX_WIDTH);
        end
        h18 = 18'(r_cfg_h);
        if (h18 < 18'd2) begin
            h18 = 18'd2;
        end else if (h18 > 18'(MAX_HEIGHT)) begin
            h18 = 18'(MAX_HEIGHT);
        end
    end
    assign w = w18[CW-1:0];
    assign h = h18[HW-1:0];

    assign lsum = sob_pkg::LUMA_R * 17'(i_red) + sob_pkg::LUMA_G * 17'(i_green)
                + sob_pkg::LUMA_B * 17'(i_blue) + sob_pkg::LUMA_RND;
    assign luma = lsum[15:8] + sob_pkg::LUMA_OFS;

    assign c_now    = (r_col >= w) ? '0 : r_col;
    assign d_now    = (r_drain >= w) ? '0 : r_drain;
    assign col0_now = (d_now == '0) ? '0 : d_now - CW'(1);
    assign col2     = ((r_drain + CW'(1)) < w) ? r_drain + CW'(1) : w - CW'(1);

    // first row replicates its own luma into the rows above
    assign pt = (r_row == '0) ? r_y : r_rd_a;
    assign pm = (r_row == '0) ? r_y : r_rd_b;
    assign need_out = (r_row != '0) && (r_c != '0);

    always_comb begin
        win_pix  = r_win;
        win_edge = r_win;
        win_dr   = r_win;
        if (r_c == '0) begin
            win_pix[0] = pt;  win_pix[1] = pt;  win_pix[2] = pt;
            win_pix[3] = pm;  win_pix[4] = pm;  win_pix[5] = pm;
            win_pix[6] = r_y; win_pix[7] = r_y; win_pix[8] = r_y;
        end else begin
            win_pix[0] = r_win[1]; win_pix[1] = r_win[2]; win_pix[2] = pt;
            win_pix[3] = r_win[4]; win_pix[4] = r_win[5]; win_pix[5] = pm;
            win_pix[6] = r_win[7]; win_pix[7] = r_win[8]; win_pix[8] = r_y;
        end
        // right border: replicate the last column
        win_edge[0] = r_win[1]; win_edge[1] = r_win[2];
        win_edge[3] = r_win[4]; win_edge[4] = r_win[5];
        win_edge[6] = r_win[7]; win_edge[7] = r_win[8];
        win_dr[2] = r_rd_a; win_dr[5] = r_rd_b; win_dr[8] = r_rd_b;
    end

    assign o_ready = (r_state == F_IDLE);

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_drain  = r_drain;
        n_c      = r_c;
        n_y      = r_y;
        n_win    = r_win;
        n_rdaddr = r_rdaddr;
        mem_we   = 1'b0;
        o_push   = 1'b0;
        o_job    = sob_pkg::grad(win_pix);
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == sob_pkg::OP_PIXEL) begin
                        if (r_row < h) begin
                            n_c      = c_now;
                            n_y      = luma;
                            n_rdaddr = c_now;
                            n_state  = F_PIX;
                        end
                    end else if (r_row >= h) begin
                        n_drain  = d_now;
                        n_rdaddr = col0_now;
                        n_state  = F_DR1;
                    end
                end
            end
            F_PIX: begin
                o_job.last = (r_c != w - CW'(1));
                if (!need_out || !i_full) begin
                    mem_we = 1'b1;
                    n_win  = win_pix;
                    o_push = need_out;
                    if ((r_c + CW'(1)) >= w) begin
                        n_col = '0;
                        n_row = r_row + HW'(1);
                    end else begin
                        n_col = r_c + CW'(1);
                    end
                    n_state = (need_out && r_c == w - CW'(1)) ? F_EDGE : F_IDLE;
                end
            end
            F_EDGE: begin
                o_job         = sob_pkg::grad(win_edge);
                o_job.row_end = 1'b1;
                o_job.last    = 1'b1;
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_win   = win_edge;
                    n_state = F_IDLE;
                end
            end
            F_DR1: begin
                n_win[0] = r_rd_a; n_win[3] = r_rd_b; n_win[6] = r_rd_b;
                n_rdaddr = r_drain;
                n_state  = F_DR2;
            end
            F_DR2: begin
                n_win[1] = r_rd_a; n_win[4] = r_rd_b; n_win[7] = r_rd_b;
                n_rdaddr = col2;
                n_state  = F_DR3;
            end
            F_DR3: begin
                o_job           = sob_pkg::grad(win_dr);
                o_job.row_end   = (r_drain == w - CW'(1));
                o_job.frame_end = (r_drain == w - CW'(1));
                o_job.last      = 1'b1;
                if (!i_full) begin
                    o_push = 1'b1;
                    n_win  = win_dr;
                    if ((r_drain + CW'(1)) >= w) begin
                        n_drain = '0;
                        n_col   = '0;
                        n_row   = '0;
                    end else begin
                        n_drain = r_drain + CW'(1);
                    end
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
            r_win   <= '0;
            r_cfg_w <= sob_pkg::WIDTH_RESET;
            r_cfg_h <= sob_pkg::HEIGHT_RESET;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            if (i_cfg_we) begin
                // any register write restarts the frame
                r_col   <= '0;
                r_row   <= '0;
                r_drain <= '0;
                if (i_cfg_index == sob_pkg::REG_WIDTH) begin
                    r_cfg_w <= i_cfg_data[11:0];
                end else begin
                    r_cfg_h <= i_cfg_data;
                end
            end else begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_drain <= n_drain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c      <= n_c;
        r_y      <= n_y;
        r_rdaddr <= n_rdaddr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_a[r_c[AW-1:0]] <= pm;
            mem_b[r_c[AW-1:0]] <= r_y;
        end
        r_rd_a <= mem_a[n_rdaddr[AW-1:0]];
        r_rd_b <= mem_b[n_rdaddr[AW-1:0]];
    end

endmodule

FILE: design/sob_back.sv
// Back of the Sobel block: squares the gradients, takes the saturated integer
// square root one bit per cycle and holds the result for the output stream.
// Depends on sob_pkg.
`timescale 1ns / 1ps

module sob_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sob_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_magnitude,
    output logic          o_row_end,
    output logic          o_frame_end,
    output logic          o_last
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_SQ   = 5'b00010,
        B_SUM  = 5'b00100,
        B_ROOT = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    t_bstate r_state;
    sob_pkg::t_job r_job;
    logic [21:0] r_sqx, r_sqy, r_s;
    logic [7:0]  r_root, r_mag;
    logic [2:0]  r_k;
    logic signed [21:0] gx_ext, gy_ext, sqx, sqy;
    logic [7:0]  trial, root_next;
    logic [15:0] trial_sq;

    assign gx_ext = 22'(r_job.gx);
    assign gy_ext = 22'(r_job.gy);
    assign sqx    = gx_ext * gx_ext;
    assign sqy    = gy_ext * gy_ext;

    assign trial     = r_root | (8'd1 << r_k);
    assign trial_sq  = 16'(trial) * 16'(trial);
    assign root_next = (22'(trial_sq) <= r_s) ? trial : r_root;

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_valid     = (r_state == B_OUT);
    assign o_magnitude = r_mag;
    assign o_row_end   = r_job.row_end;
    assign o_frame_end = r_job.frame_end;
    assign o_last      = r_job.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: if (!i_empty) r_state <= B_SQ;
                B_SQ:   r_state <= B_SUM;
                B_SUM:  r_state <= B_ROOT;
                B_ROOT: if (r_k == 3'd0) r_state <= B_OUT;
                B_OUT:  if (i_ready) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_SQ) begin
            r_sqx <= sqx;
            r_sqy <= sqy;
        end
        if (r_state == B_SUM) begin
            r_s    <= r_sqx + r_sqy;
            r_root <= '0;
            r_k    <= 3'd7;
        end
        if (r_state == B_ROOT) begin
            r_root <= root_next;
            r_k    <= r_k - 3'd1;
            if (r_k == 3'd0) begin
                // saturate: anything at or above 256 squared reads as full scale
                r_mag <= (r_s >= 22'd65536) ? 8'd255 : root_next;
            end
        end
    end

endmodule

FILE: design/sobel_edge_magnitude.sv
// Top level of the streaming Sobel edge magnitude block.
// Instantiates sob_front, sob_queue and sob_back; depends on sob_pkg.
//
// Slave stream carries BGR pixels in raster order (tuser 0) or drain requests
// (tuser 1). The master stream returns one 8-bit gradient magnitude per
// result, tlast on the last pixel of an output row, tuser[0] on the last
// pixel of the frame, tuser[1] on the last result of the causing request.
// Output trails input by one row and one column; after the last input row
// send one drain request per pixel of that row to flush it.
// The config port sets width (index 0) and height (index 1); any write
// restarts the frame. Write only while the block is idle.
// The front takes a new request only in its idle state: a pixel passes through
// its pixel state (and the edge state at a row end), a drain through its read
// states, paced by the single line store read port. The back works out its
// square root one bit per cycle and takes no new job until its result is taken.
// A 4-entry queue decouples the two halves.
// Reset clears counts, window and queue and loads 640x480; line stores are
// not cleared. A stalled receiver holds the output; the queue fills and
// then tready drops until room frees up.
`timescale 1ns / 1ps

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // blue, green, red
    input  logic        i_s_tuser,   // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // magnitude
    output logic        o_m_tlast,   // row_end
    output logic [1:0]  o_m_tuser    // frame_end, last_of_step
);

    logic          push, full, pop, empty;
    sob_pkg::t_job job_in, job_out;

    sob_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_opcode   (i_s_tuser),
        .i_blue     (i_s_tdata[7:0]),
        .i_green    (i_s_tdata[15:8]),
        .i_red      (i_s_tdata[23:16]),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    sob_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (job_out)
    );

    sob_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_magnitude(o_m_tdata),
        .o_row_end  (o_m_tlast),
        .o_frame_end(o_m_tuser[0]),
        .o_last     (o_m_tuser[1])
    );

endmodule

FILE: tb/sobel_edge_magnitude_tb.sv
// Self-checking testbench for sobel_edge_magnitude: random BGR frames of many sizes,
// drain and stray requests, and a predictor kept in the bench. Depends on sob_pkg.
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

    localparam int MAXW = 2048;
    localparam int MAXH = 4096;
    localparam int CYCLE_LIMIT = 3000000;

    typedef enum logic [1:0] {K_REQ, K_CFG, K_PAUSE} t_kind;

    typedef struct {
        t_kind       kind;
        logic        op;
        logic [23:0] bgr;
        logic        idx;
        logic [12:0] val;
    } t_cmd;

    typedef struct {
        logic [7:0] mag;
        logic       row_end;
        logic       frame_end;
        logic       last;
    } t_edge;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = sob_pkg::REG_WIDTH;
    logic [12:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // blue, green, red
    logic        i_s_tuser = sob_pkg::OP_PIXEL;   // opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;   // magnitude
    logic        o_m_tlast;   // row_end
    logic [1:0]  o_m_tuser;   // frame_end, last_of_step

    sobel_edge_magnitude dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  luma_prev2 [MAXW];
    logic [7:0]  luma_prev1 [MAXW];
    logic [7:0]  win [9];
    int          col_pos, row_pos, drain_pos;
    logic [11:0] width_reg = 12'd640;
    logic [12:0] height_reg = 13'd480;

    t_cmd  pending [$];
    t_edge edges_due [$];
    int    errors = 0, cycles = 0, pix_sent = 0, drains_sent = 0, edges_seen = 0;
    int    cfg_writes = 0;
    logic  calm = 1'b0;
    logic  req_taken = 1'b0;
    logic  edge_taken = 1'b0;
    int    tx_gap = 0, rx_gap = 0, rx_hold = 0, settle = 0;
    logic  hold_done = 1'b0;

    function automatic int eff_w();
        return (width_reg < 2) ? 2 : (width_reg > MAXW) ? MAXW : int'(width_reg);
    endfunction

    function automatic int eff_h();
        return (height_reg < 2) ? 2 : (height_reg > MAXH) ? MAXH : int'(height_reg);
    endfunction

    function automatic logic [7:0] sobel_mag();
        int gx, gy, s, r, t;
        gx = (win[2] + 2 * win[5] + win[8]) - (win[0] + 2 * win[3] + win[6]);
        gy = (win[6] + 2 * win[7] + win[8]) - (win[0] + 2 * win[1] + win[2]);
        s = gx * gx + gy * gy;
        if (s >= 65536) return 8'd255;
        r = 0;
        for (int b = 128; b != 0; b = b >> 1) begin
            t = r | b;
            if (t * t <= s) r = t;
        end
        return 8'(r);
    endfunction

    function automatic void shift_in(logic [7:0] t, logic [7:0] m, logic [7:0] b);
        logic [7:0] c [3];
        c[0] = t; c[1] = m; c[2] = b;
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
            win[i*3+2] = c[i];
        end
    endfunction

    function automatic void add_edge(logic re, logic fe, logic last);
        t_edge e;
        e.mag = sobel_mag();
        e.row_end = re;
        e.frame_end = fe;
        e.last = last;
        edges_due.push_back(e);
    endfunction

    function automatic void predict_request(logic op, logic [23:0] bgr);
        int w, h, c, d, cols [3];
        logic [16:0] acc;
        logic [7:0] y, t, m;
        w = eff_w();
        h = eff_h();
        if (op == sob_pkg::OP_PIXEL) begin
            if (row_pos >= h) return;
            if (col_pos >= w) col_pos = 0;
            c = col_pos;
            acc = sob_pkg::LUMA_R * bgr[23:16] + sob_pkg::LUMA_G * bgr[15:8]
                + sob_pkg::LUMA_B * bgr[7:0] + sob_pkg::LUMA_RND;
            y = acc[15:8] + sob_pkg::LUMA_OFS;
            if (row_pos == 0) begin
                t = y; m = y;
            end else begin
                t = luma_prev2[c]; m = luma_prev1[c];
            end
            luma_prev2[c] = m;
            luma_prev1[c] = y;
            if (c == 0) begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        win[i*3+j] = (i == 0) ? t : (i == 1) ? m : y;
            end else begin
                shift_in(t, m, y);
            end
            if (row_pos >= 1 && c >= 1) begin
                if (c == w - 1) begin
                    add_edge(1'b0, 1'b0, 1'b0);
                    shift_in(win[2], win[5], win[8]);
                    add_edge(1'b1, 1'b0, 1'b1);
                end else begin
                    add_edge(1'b0, 1'b0, 1'b1);
                end
            end
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end else begin
            if (row_pos < h) return;
            if (drain_pos >= w) drain_pos = 0;
            d = drain_pos;
            cols[0] = (d == 0) ? 0 : d - 1;
            cols[1] = d;
            cols[2] = (d + 1 < w) ? d + 1 : w - 1;
            for (int j = 0; j < 3; j++) begin
                win[j] = luma_prev2[cols[j]];
                win[3+j] = luma_prev1[cols[j]];
                win[6+j] = luma_prev1[cols[j]];
            end
            add_edge(d == w - 1, d == w - 1, 1'b1);
            drain_pos = d + 1;
            if (drain_pos >= w) begin
                drain_pos = 0; col_pos = 0; row_pos = 0;
            end
        end
    endfunction

    function automatic void predict_write(logic idx, logic [12:0] val);
        if (idx == sob_pkg::REG_WIDTH) width_reg = val[11:0];
        else height_reg = val;
        col_pos = 0; row_pos = 0; drain_pos = 0;
    endfunction

    // stimulus builders
    function automatic void add_req(logic op, logic [23:0] bgr);
        t_cmd c;
        c.kind = K_REQ; c.op = op; c.bgr = bgr; c.idx = sob_pkg::REG_WIDTH; c.val = '0;
        pending.push_back(c);
    endfunction

    function automatic void add_cfg(logic idx, logic [12:0] val);
        t_cmd c;
        c.kind = K_CFG; c.op = sob_pkg::OP_PIXEL; c.bgr = '0; c.idx = idx; c.val = val;
        pending.push_back(c);
    endfunction

    function automatic void add_pause();
        t_cmd c;
        c.kind = K_PAUSE; c.op = sob_pkg::OP_PIXEL; c.bgr = '0;
        c.idx = sob_pkg::REG_WIDTH; c.val = '0;
        pending.push_back(c);
    endfunction

    // one frame of random pixels; noise adds stray drains and surplus pixels
    function automatic int add_frame(int w, int h, bit noise);
        int n = 0;
        for (int p = 0; p < w * h; p++) begin
            if (noise && $urandom_range(0, 29) == 0)
                add_req(sob_pkg::OP_DRAIN, 24'($urandom));
            add_req(sob_pkg::OP_PIXEL, 24'($urandom));
            n++;
        end
        if (noise && $urandom_range(0, 2) == 0) add_req(sob_pkg::OP_PIXEL, 24'($urandom));
        for (int d = 0; d < w; d++) begin
            add_req(sob_pkg::OP_DRAIN, 24'($urandom));
            n++;
        end
        return n;
    endfunction

    initial begin
        int count, w, h;
        // smallest frame via clamping, extreme pixels, stray requests
        add_cfg(sob_pkg::REG_WIDTH, 13'd1);
        add_cfg(sob_pkg::REG_HEIGHT, 13'd0);
        add_req(sob_pkg::OP_DRAIN, 24'hFFFFFF);
        add_req(sob_pkg::OP_PIXEL, 24'h000000);
        add_req(sob_pkg::OP_PIXEL, 24'hFFFFFF);
        add_req(sob_pkg::OP_PIXEL, 24'hFFFFFF);
        add_req(sob_pkg::OP_PIXEL, 24'h000000);
        add_req(sob_pkg::OP_PIXEL, 24'hFFFFFF);
        add_req(sob_pkg::OP_DRAIN, 24'h000000);
        add_req(sob_pkg::OP_DRAIN, 24'h000000);
        // 4x3 with hard vertical and horizontal edges
        add_cfg(sob_pkg::REG_WIDTH, 13'd4);
        add_cfg(sob_pkg::REG_HEIGHT, 13'd3);
        for (int p = 0; p < 12; p++)
            add_req(sob_pkg::OP_PIXEL,
                    ((p % 4) < 2) ^ (p >= 8) ? 24'hFFFFFF : 24'h000000);
        for (int d = 0; d < 4; d++) add_req(sob_pkg::OP_DRAIN, 24'h0);
        add_pause();
        // width clamps down to the maximum; partial first row, then abandoned
        add_cfg(sob_pkg::REG_HEIGHT, 13'd2);
        add_cfg(sob_pkg::REG_WIDTH, 13'd4095);
        for (int p = 0; p < 64; p++) add_req(sob_pkg::OP_PIXEL, 24'($urandom));
        // height clamps too; overwritten before any request
        add_cfg(sob_pkg::REG_HEIGHT, 13'd8191);
        count = 0;
        while (count < 1260) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
            h = $urandom_range(2, 8);
            add_cfg(sob_pkg::REG_HEIGHT, 13'(h));
            add_cfg(sob_pkg::REG_WIDTH, 13'(w));
            count += add_frame(w, h, 1'b1);
            if ($urandom_range(0, 1) == 0) count += add_frame(w, h, 1'b1);
            if ($urandom_range(0, 5) == 0) begin
                // abandoned frame: restart by a register write mid-frame
                for (int p = 0; p < $urandom_range(1, w * h); p++) begin
                    add_req(sob_pkg::OP_PIXEL, 24'($urandom));
                    count++;
                end
            end
            if ($urandom_range(0, 3) == 0) add_pause();
        end
    end

    // accept, predict, check
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            predict_request(i_s_tuser, i_s_tdata);
            if (i_s_tuser == sob_pkg::OP_PIXEL) pix_sent++;
            else drains_sent++;
            req_taken = 1'b1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            edges_seen++;
            edge_taken = 1'b1;
            if (edges_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result mag=%0d tlast=%0b tuser=%b", $time,
                         o_m_tdata, o_m_tlast, o_m_tuser);
            end else begin
                t_edge e;
                e = edges_due.pop_front();
                if (o_m_tdata !== e.mag || o_m_tlast !== e.row_end ||
                    o_m_tuser[0] !== e.frame_end || o_m_tuser[1] !== e.last) begin
                    errors++;
                    $display("%0t: mismatch expected mag=%0d re=%0b fe=%0b last=%0b",
                             $time, e.mag, e.row_end, e.frame_end, e.last);
                    $display("%0t:          actual   mag=%0d re=%0b fe=%0b last=%0b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser[0], o_m_tuser[1]);
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_cfg_we = 1'b0;
            if (req_taken) begin
                req_taken = 1'b0;
                i_s_tvalid = 1'b0;
                if ((pix_sent + drains_sent) % 64 == 0) calm = ($urandom_range(0, 2) == 0);
                tx_gap = calm ? 0 : $urandom_range(0, 19);
            end
            if (!i_s_tvalid && pending.size() != 0) begin
                if (pending[0].kind != K_REQ) begin
                    // hold until the block is drained and quiet
                    if (edges_due.size() != 0) settle = 60;
                    else if (settle > 0) settle--;
                    else begin
                        if (pending[0].kind == K_CFG) begin
                            i_cfg_we = 1'b1;
                            i_cfg_index = pending[0].idx;
                            i_cfg_data = pending[0].val;
                            predict_write(pending[0].idx, pending[0].val);
                            cfg_writes++;
                        end
                        void'(pending.pop_front());
                        settle = 60;
                    end
                end else if (tx_gap > 0) begin
                    tx_gap--;
                end else begin
                    t_cmd c;
                    c = pending.pop_front();
                    i_s_tvalid = 1'b1;
                    i_s_tuser = c.op;
                    i_s_tdata = c.bgr;
                end
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (edge_taken) begin
                edge_taken = 1'b0;
                rx_gap = calm ? 0 : $urandom_range(0, 19);
                // one long hold-off so the queue fills and input stalls
                if (!hold_done && edges_seen >= 200) begin
                    hold_done = 1'b1;
                    rx_hold = 400;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending.size() == 0 && !i_s_tvalid && edges_due.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d pixels, %0d drain requests, %0d register writes, %0d results.",
                 pix_sent, drains_sent, cfg_writes, edges_seen);
        if (errors == 0 && edges_due.size() == 0) begin
            $display("sobel_edge_magnitude test passed");
        end else begin
            $display("sobel_edge_magnitude test failed");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding.", cycles, edges_due.size());
        $display("sobel_edge_magnitude test failed");
        $finish;
    end

endmodule
